@@ sv/rpc_message_header_parser_assert.svh @@
// ----------------------------------------------------------------------------
// RPC message header parser assertion macros
// Shared concurrent assertion forms. The clock is clk and the reset is rst_n
// in every module that uses them.
// ----------------------------------------------------------------------------
`ifndef RPC_MESSAGE_HEADER_PARSER_ASSERT_SVH
`define RPC_MESSAGE_HEADER_PARSER_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define RMHP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define RMHP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ sv/rmhp_pkg.sv @@
// ----------------------------------------------------------------------------
// RPC message header parser package
// Shared constants and payload types of the header parser.
// ----------------------------------------------------------------------------
package rmhp_pkg;

  localparam int unsigned RMHP_MAX_MSG_BYTES = 65536;
  localparam int unsigned RMHP_QUEUE_DEPTH   = 4;
  localparam logic [31:0] RPC_VERSION_RESET  = 32'd2;

  // Result status codes.
  localparam logic [1:0] ST_FIELD     = 2'd0;
  localparam logic [1:0] ST_END_OK    = 2'd1;
  localparam logic [1:0] ST_END_TRUNC = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  field_id;
    logic [31:0] field_value;
    logic [1:0]  parse_status;
    logic        last_result;
  } out_item_t;

  // Results caused by one byte: one or two.
  typedef struct packed {
    logic      two;
    out_item_t first;
    out_item_t second;
  } pair_t;

  typedef struct packed {
    logic  valid;
    pair_t pair;
  } push_t;

endpackage

@@ sv/rmhp_front.sv @@
// ----------------------------------------------------------------------------
// RPC message header parser front end
// Assembles header fields byte by byte, steps the parse phase and pushes the
// results that each byte causes into the result queue.
// ----------------------------------------------------------------------------
`include "rpc_message_header_parser_assert.svh"

module rmhp_front #(
  parameter int unsigned MAX_MSG_BYTES = rmhp_pkg::RMHP_MAX_MSG_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               byte_valid,
  input  rmhp_pkg::in_item_t byte_item,
  output rmhp_pkg::push_t    push
);

  localparam int unsigned OFFS_W = $clog2(MAX_MSG_BYTES + 1);
  localparam logic [OFFS_W-1:0] OFFS_MAX = OFFS_W'(MAX_MSG_BYTES);

  localparam logic [4:0]  ID_BODY_LEN       = 5'd26;
  localparam logic [31:0] MSG_CALL          = 32'd0;
  localparam logic [31:0] MSG_REPLY         = 32'd1;
  localparam logic [31:0] STAT_ACCEPTED     = 32'd0;
  localparam logic [31:0] STAT_DENIED       = 32'd1;
  localparam logic [31:0] ACC_PROG_MISMATCH = 32'd2;
  localparam logic [31:0] REJ_RPC_MISMATCH  = 32'd0;
  localparam logic [31:0] REJ_AUTH_ERROR    = 32'd1;

  // Phase codes double as the field ids of the fields they collect.
  typedef enum logic [4:0] {
    PH_HOST, PH_PORT, PH_XID, PH_MTYPE, PH_RPCVERS, PH_PROG, PH_VERS, PH_PROC,
    PH_CFLAV, PH_CCOUNT, PH_CSKIP, PH_VFLAV, PH_VCOUNT, PH_VSKIP, PH_STAT,
    PH_AFLAV, PH_ACOUNT, PH_ASKIP, PH_ASTAT, PH_PLOW, PH_PHIGH, PH_RSTAT,
    PH_RLOW, PH_RHIGH, PH_AUTHSTAT, PH_BODY
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [31:0]         shift_r, shift_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic [31:0]         skip_r, skip_nxt;
  logic [OFFS_W-1:0]   off_r, off_nxt;
  logic [OFFS_W-1:0]   body_r, body_nxt;
  logic [31:0]         ver_r;

  logic [OFFS_W-1:0]   off_inc;
  logic [31:0]         fval;
  logic [32:0]         psum;
  logic [31:0]         padded;
  logic [31:0]         skip_dec;
  logic                complete;
  logic                done_now;
  logic                a_v, b_v;
  rmhp_pkg::out_item_t res_a, res_b;

  assign off_inc  = (off_r < OFFS_MAX) ? off_r + OFFS_W'(1) : OFFS_MAX;
  assign fval     = {shift_r[23:0], byte_item.data_byte};
  assign psum     = {1'b0, fval} + 33'd3;
  assign padded   = psum[32] ? 32'hFFFF_FFFF : {psum[31:2], 2'b00};
  assign skip_dec = (skip_r == 32'd0) ? 32'd0 : skip_r - 32'd1;
  assign complete = (phase_r == PH_PORT) ? (cnt_r == 2'd1) : (cnt_r == 2'd3);

  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    skip_nxt  = skip_r;
    off_nxt   = off_r;
    body_nxt  = body_r;
    done_now  = 1'b0;
    a_v       = 1'b0;
    b_v       = 1'b0;
    res_a     = '{field_id: 5'(phase_r), field_value: fval,
                  parse_status: rmhp_pkg::ST_FIELD, last_result: 1'b0};
    res_b     = '{field_id: 5'(PH_BODY), field_value: 32'd0,
                  parse_status: rmhp_pkg::ST_FIELD, last_result: 1'b0};

    if (byte_valid) begin
      if (phase_r == PH_CSKIP || phase_r == PH_VSKIP || phase_r == PH_ASKIP) begin
        // The first byte of opaque data reports where the data starts.
        if (cnt_r == 2'd0) begin
          a_v                = 1'b1;
          res_a.field_value = 32'(off_r);
          cnt_nxt            = 2'd1;
        end
        skip_nxt = skip_dec;
        if (skip_dec == 32'd0) begin
          cnt_nxt = 2'd0;
          if (phase_r == PH_CSKIP) begin
            phase_nxt = PH_VFLAV;
          end else if (phase_r == PH_ASKIP) begin
            phase_nxt = PH_ASTAT;
          end else begin
            phase_nxt = PH_BODY;
            body_nxt  = off_inc;
            done_now  = 1'b1;
          end
        end
      end else if (phase_r < PH_BODY) begin
        shift_nxt = fval;
        if (complete) begin
          shift_nxt = 32'd0;
          cnt_nxt   = 2'd0;
          a_v       = 1'b1;
          unique case (phase_r)
            PH_HOST:  phase_nxt = PH_PORT;
            PH_PORT:  phase_nxt = PH_XID;
            PH_XID:   phase_nxt = PH_MTYPE;
            PH_MTYPE: begin
              if (fval == MSG_CALL)       phase_nxt = PH_RPCVERS;
              else if (fval == MSG_REPLY) phase_nxt = PH_STAT;
              else                        phase_nxt = PH_BODY;
            end
            PH_RPCVERS: phase_nxt = (fval == ver_r) ? PH_PROG : PH_BODY;
            PH_PROG:    phase_nxt = PH_VERS;
            PH_VERS:    phase_nxt = PH_PROC;
            PH_PROC:    phase_nxt = PH_CFLAV;
            PH_CFLAV:   phase_nxt = PH_CCOUNT;
            PH_CCOUNT: begin
              phase_nxt = (fval == 32'd0) ? PH_VFLAV : PH_CSKIP;
              skip_nxt  = (fval == 32'd0) ? skip_r : padded;
            end
            PH_VFLAV:   phase_nxt = PH_VCOUNT;
            PH_VCOUNT: begin
              phase_nxt = (fval == 32'd0) ? PH_BODY : PH_VSKIP;
              skip_nxt  = (fval == 32'd0) ? skip_r : padded;
            end
            PH_STAT: begin
              if (fval == STAT_ACCEPTED)    phase_nxt = PH_AFLAV;
              else if (fval == STAT_DENIED) phase_nxt = PH_RSTAT;
              else                          phase_nxt = PH_BODY;
            end
            PH_AFLAV:   phase_nxt = PH_ACOUNT;
            PH_ACOUNT: begin
              phase_nxt = (fval == 32'd0) ? PH_ASTAT : PH_ASKIP;
              skip_nxt  = (fval == 32'd0) ? skip_r : padded;
            end
            PH_ASTAT:   phase_nxt = (fval == ACC_PROG_MISMATCH) ? PH_PLOW : PH_BODY;
            PH_PLOW:    phase_nxt = PH_PHIGH;
            PH_RSTAT: begin
              if (fval == REJ_RPC_MISMATCH)    phase_nxt = PH_RLOW;
              else if (fval == REJ_AUTH_ERROR) phase_nxt = PH_AUTHSTAT;
              else                             phase_nxt = PH_BODY;
            end
            PH_RLOW:    phase_nxt = PH_RHIGH;
            default:    phase_nxt = PH_BODY;
          endcase
          if (phase_nxt == PH_BODY) begin
            body_nxt = off_inc;
            done_now = 1'b1;
          end
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end else begin
        phase_nxt = PH_BODY;
      end

      if (byte_item.end_of_message) begin
        b_v               = 1'b1;
        res_b.field_id    = ID_BODY_LEN;
        res_b.last_result = 1'b1;
        if (phase_nxt == PH_BODY) begin
          res_b.field_value  = 32'(off_inc - body_nxt);
          res_b.parse_status = rmhp_pkg::ST_END_OK;
        end else begin
          res_b.parse_status = rmhp_pkg::ST_END_TRUNC;
        end
        phase_nxt = PH_HOST;
        shift_nxt = 32'd0;
        cnt_nxt   = 2'd0;
        skip_nxt  = 32'd0;
        off_nxt   = '0;
        body_nxt  = '0;
      end else begin
        if (done_now) begin
          b_v               = 1'b1;
          res_b.field_value = 32'(body_nxt);
        end
        off_nxt = off_inc;
      end
    end
  end

  always_comb begin
    push.valid       = a_v || b_v;
    push.pair.two    = a_v && b_v;
    push.pair.first  = a_v ? res_a : res_b;
    push.pair.second = res_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HOST;
      shift_r <= 32'd0;
      cnt_r   <= 2'd0;
      skip_r  <= 32'd0;
      off_r   <= '0;
      body_r  <= '0;
      ver_r   <= rmhp_pkg::RPC_VERSION_RESET;
    end else begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      cnt_r   <= cnt_nxt;
      skip_r  <= skip_nxt;
      off_r   <= off_nxt;
      body_r  <= body_nxt;
      if (cfg_wr_en) begin
        ver_r <= cfg_wr_data;
      end
    end
  end

  `RMHP_ASSERT_IMPLY(a_skip_len, (phase_r == PH_CSKIP || phase_r == PH_VSKIP || phase_r == PH_ASKIP), (skip_r != 32'd0), "skip phase entered with zero length")
  `RMHP_ASSERT_IMPLY(a_eom_last, (byte_valid && byte_item.end_of_message), (push.valid && (push.pair.two ? push.pair.second.last_result : push.pair.first.last_result)), "end of message without final result")

endmodule

@@ sv/rmhp_queue.sv @@
// ----------------------------------------------------------------------------
// RPC message header parser result queue
// Short queue of result pairs between the parser and the output stage.
// ----------------------------------------------------------------------------
`include "rpc_message_header_parser_assert.svh"

module rmhp_queue #(
  parameter int unsigned DEPTH = rmhp_pkg::RMHP_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  rmhp_pkg::push_t push,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output rmhp_pkg::pair_t head
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  rmhp_pkg::pair_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push.valid && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push.valid) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr_r] <= push.pair;
    end
  end

  `RMHP_ASSERT_IMPLY(a_no_overflow, push.valid, !full, "push into a full queue")
  `RMHP_ASSERT_IMPLY(a_no_underflow, pop, !empty, "pop from an empty queue")

endmodule

@@ sv/rmhp_back.sv @@
// ----------------------------------------------------------------------------
// RPC message header parser output stage
// Splits queued result pairs into single results and holds the one on offer.
// ----------------------------------------------------------------------------
`include "rpc_message_header_parser_assert.svh"

module rmhp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  rmhp_pkg::pair_t     q_head,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output rmhp_pkg::out_item_t out_item
);

  logic                hold_v_r, hold_v_nxt;
  logic                sec_v_r, sec_v_nxt;
  rmhp_pkg::out_item_t hold_r, hold_nxt;
  rmhp_pkg::out_item_t sec_r, sec_nxt;
  logic                hold_free;

  assign hold_free = !hold_v_r || out_pop;
  assign q_pop     = hold_free && !sec_v_r && !q_empty;
  assign out_empty = !hold_v_r;
  assign out_item  = hold_r;

  always_comb begin
    hold_v_nxt = hold_v_r;
    sec_v_nxt  = sec_v_r;
    hold_nxt   = hold_r;
    sec_nxt    = sec_r;
    if (hold_free) begin
      if (sec_v_r) begin
        hold_nxt   = sec_r;
        hold_v_nxt = 1'b1;
        sec_v_nxt  = 1'b0;
      end else if (!q_empty) begin
        hold_nxt   = q_head.first;
        sec_nxt    = q_head.second;
        hold_v_nxt = 1'b1;
        sec_v_nxt  = q_head.two;
      end else begin
        hold_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      sec_v_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      sec_v_r  <= sec_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    sec_r  <= sec_nxt;
  end

  `RMHP_ASSERT_IMPLY(a_second_behind_first, sec_v_r, hold_v_r, "second result waiting without a first")

endmodule

@@ sv/rpc_message_header_parser.sv @@
// ----------------------------------------------------------------------------
// RPC message header parser
// Byte-serial parser of ONC RPC v2 message headers with a host and port
// prefix, reporting each header field as an id and value.
// ----------------------------------------------------------------------------
// The block takes one message byte per clock cycle on a queue-style input
// (push/full) and offers results on a queue-style output (empty/pop). Every
// byte is parsed in the cycle it is accepted: the front end shifts it into
// the field being assembled, counts it and steps the parse phase, and any
// results it causes (a completed field, the start offset of opaque auth
// data, the body offset when the header ends, and the final end-of-message
// result with the body length and header status) are written as one pair
// into a short queue. The output stage hands out one result per cycle while
// the consumer pops, so a byte that causes two results holds the output for
// both; with the consumer popping every cycle the front end takes one byte
// per cycle while the queue has room. The first result of a byte passes
// through a queue slot and the output-stage hold register on its way to the
// result ports. Input stalls only when the result queue (QUEUE_DEPTH pairs)
// is full. The rpc version register is written through cfg_wr_en/cfg_wr_data
// and should change only while no message is in progress. Byte offsets
// saturate at MAX_MSG_BYTES.

module rpc_message_header_parser #(
  parameter int unsigned MAX_MSG_BYTES = rmhp_pkg::RMHP_MAX_MSG_BYTES,
  parameter int unsigned QUEUE_DEPTH   = rmhp_pkg::RMHP_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  rmhp_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output rmhp_pkg::out_item_t out_item,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data
);

  // A byte transfer happens when the producer pushes and the queue has room.
  logic            byte_accept;
  rmhp_pkg::push_t push;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  rmhp_pkg::pair_t q_head;

  assign in_full     = q_full;
  assign byte_accept = in_push && !q_full;

  // Front end: field assembly and phase stepping, one byte per cycle while the queue has room.
  rmhp_front #(
    .MAX_MSG_BYTES(MAX_MSG_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .byte_valid (byte_accept),
    .byte_item  (in_item),
    .push       (push)
  );

  // Decoupling queue of result pairs.
  rmhp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .full (q_full),
    .pop  (q_pop),
    .empty(q_empty),
    .head (q_head)
  );

  // Back end: presents one result at a time to the consumer.
  rmhp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

endmodule
